// File: rtl/clpt_pkg.sv
// ----------------------------------------------------------------------------
// clpt_pkg
// Shared types and constants for the closest point on segment set block.
// ----------------------------------------------------------------------------
package clpt_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int COORD_W      = 32;
    localparam int IDX_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int NORM_W       = 18;
    localparam int NORM_FRAC    = 16;
    localparam int DIST_W       = 33;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int SQ_W         = 2 * DIFF_W + 1;
    localparam int DOT_W        = 2 * DIFF_W + 2;
    localparam int QB           = DIFF_W + 1;
    localparam int PROD_W       = SQ_W + DIFF_W;
    localparam int MUL_W        = DIFF_W + 2;
    localparam int SQRT_W       = DOT_W / 2;
    localparam int SQREM_W      = SQRT_W + 3;
    localparam int NDIV_BITS    = NORM_FRAC + 1;
    localparam int STEP_W       = $clog2(QB + 1);
    localparam int SEG_W        = 4 * COORD_W + 2 * NORM_W;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_HIT   = 2'd2,
        STAT_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        TGT_NX = 2'd0,
        TGT_NY = 2'd1,
        TGT_PX = 2'd2,
        TGT_PY = 2'd3
    } t_tgt;

    typedef enum logic [4:0] {
        S_IDLE, S_NSQ1, S_NSQ2, S_SQRT, S_NDX, S_NDY, S_DIV, S_WRITE,
        S_RD, S_DIFF, S_L1, S_L2, S_D1, S_D2, S_CLS,
        S_PX0, S_PX1, S_PY0, S_PY1, S_E0, S_E1, S_E2, S_CMP, S_RES
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic [COORD_W-1:0] nx;
        logic [COORD_W-1:0] ny;
        logic [COORD_W-1:0] qx;
        logic [COORD_W-1:0] qy;
    } t_item;

    typedef struct packed {
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic [NORM_W-1:0]  nx;
        logic [NORM_W-1:0]  ny;
    } t_seg;

    typedef struct packed {
        t_status            status;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [NORM_W-1:0]  nx;
        logic [NORM_W-1:0]  ny;
        logic [DIST_W-1:0]  distance;
    } t_result;

endpackage

// File: rtl/closest_point_on_segment_set_top.sv
// ----------------------------------------------------------------------------
// closest_point_on_segment_set_top
// Table of up to 64 2D segments answering closest point queries.
//
// Input stream: tuser carries the operation (append, clear, query), tdata the
// segment endpoints, the raw normal and the query point. Every word yields
// exactly one output word: tuser holds the status, tdata the closest point,
// the winning unit normal and the distance.
// Append runs a 34-step square root and two 17-step divisions of the normal.
// A query walks all N segments, with two 34-step divisions for each segment
// whose projection lands inside it, then a 34-step square root.
// One word is in work at a time; a two-word input queue and an output
// register let the source and sink stall independently.
// Reset empties the table. If the sink holds tready low the result waits in
// the output register and the sequencer waits behind it.
// ----------------------------------------------------------------------------
module closest_point_on_segment_set_top import clpt_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // start_x, start_y, end_x, end_y, normal_x, normal_y, query_x, query_y
    input  logic [255:0] s_axis_tdata,
    // operation
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // nearest_x, nearest_y, nearest_normal_x, nearest_normal_y, distance, pad
    output logic [135:0] m_axis_tdata,
    // status
    output logic [1:0]   m_axis_tuser
);

    logic    q_valid;
    logic    q_pop;
    t_item   q_item;
    t_result res;

    clpt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (s_axis_tuser),
        .i_data  (s_axis_tdata),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    clpt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_pop    (q_pop),
        .i_item   (q_item),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (res)
    );

    assign m_axis_tuser = res.status;
    assign m_axis_tdata = {3'b000, res.distance, res.ny, res.nx, res.y, res.x};

endmodule

// File: rtl/clpt_ram.sv
// ----------------------------------------------------------------------------
// clpt_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module clpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/clpt_front.sv
// ----------------------------------------------------------------------------
// clpt_front
// Input stage: decode the operation and queue words for the back end.
// ----------------------------------------------------------------------------
module clpt_front import clpt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_op,
    input  logic [8*COORD_W-1:0] i_data,
    output logic                 o_valid,
    input  logic                 i_pop,
    output t_item                o_item
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;
    t_item      w_item;

    always_comb begin
        unique case (i_op)
            2'd0:    w_item.op = OP_APPEND;
            2'd1:    w_item.op = OP_CLEAR;
            2'd2:    w_item.op = OP_QUERY;
            default: w_item.op = OP_NOP;
        endcase
        w_item.sx = i_data[0*COORD_W +: COORD_W];
        w_item.sy = i_data[1*COORD_W +: COORD_W];
        w_item.ex = i_data[2*COORD_W +: COORD_W];
        w_item.ey = i_data[3*COORD_W +: COORD_W];
        w_item.nx = i_data[4*COORD_W +: COORD_W];
        w_item.ny = i_data[5*COORD_W +: COORD_W];
        w_item.qx = i_data[6*COORD_W +: COORD_W];
        w_item.qy = i_data[7*COORD_W +: COORD_W];
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_pop;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// File: rtl/clpt_back.sv
// ----------------------------------------------------------------------------
// clpt_back
// Sequencer: segment table, shared multiplier, divider and square root.
// ----------------------------------------------------------------------------
module clpt_back import clpt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_pop,
    input  t_item   i_item,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    t_state                    r_state, n_state;
    t_item                     r_item, n_item;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [CNT_W-1:0]          r_idx, n_idx;
    logic [STEP_W-1:0]         r_step, n_step;
    t_tgt                      r_tgt, n_tgt;
    logic                      r_sq_norm, n_sq_norm;
    logic signed [DIFF_W-1:0]  r_dx, n_dx, r_dy, n_dy, r_wx, n_wx, r_wy, n_wy;
    logic [SQ_W-1:0]           r_len2, n_len2, r_d2, n_d2, r_best, n_best;
    logic [SQ_W-1:0]           r_div, n_div;
    logic signed [DOT_W-1:0]   r_dot, n_dot;
    logic [PROD_W-1:0]         r_acc, n_acc;
    logic [DOT_W-1:0]          r_rem, n_rem;
    logic [QB-1:0]             r_nlo, n_nlo, r_quo, n_quo;
    logic [COORD_W-1:0]        r_px, n_px, r_py, n_py;
    logic signed [DIFF_W-1:0]  r_ex, n_ex, r_ey, n_ey;
    logic [COORD_W-1:0]        r_bx, n_bx, r_by, n_by;
    logic [NORM_W-1:0]         r_bnx, n_bnx, r_bny, n_bny, r_nnx, n_nnx, r_nny, n_nny;
    logic [DOT_W-1:0]          r_sq_op, n_sq_op;
    logic [SQREM_W-1:0]        r_sq_rem, n_sq_rem;
    logic [SQRT_W-1:0]         r_root, n_root;
    logic [COORD_W-1:0]        r_nlen, n_nlen;
    t_result                   r_res, n_res, r_out, n_out;
    logic                      r_out_valid, n_out_valid;

    t_seg                      rd_seg;
    t_seg                      wr_seg;
    logic                      ram_we;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    logic [DIFF_W-1:0]         abs_dx, abs_dy;
    logic [DOT_W-1:0]          div_rs;
    logic                      div_ge;
    logic [QB-1:0]             quo_new;
    logic [SQREM_W-1:0]        sq_rs, sq_trial;
    logic                      sq_ge;
    logic [SQRT_W-1:0]         root_new;
    logic                      last_step;
    logic                      slot_free;

    clpt_ram #(
        .WIDTH (SEG_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (wr_seg),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rd_seg)
    );

    assign abs_dx    = r_dx[DIFF_W-1] ? DIFF_W'(-r_dx) : DIFF_W'(r_dx);
    assign abs_dy    = r_dy[DIFF_W-1] ? DIFF_W'(-r_dy) : DIFF_W'(r_dy);
    assign last_step = (r_step == STEP_W'(1));
    assign slot_free = !r_out_valid || i_ready;

    assign div_rs  = {r_rem[DOT_W-2:0], r_nlo[QB-1]};
    assign div_ge  = (div_rs >= DOT_W'(r_div));
    assign quo_new = {r_quo[QB-2:0], div_ge};

    assign sq_rs    = {r_sq_rem[SQREM_W-3:0], r_sq_op[DOT_W-1 -: 2]};
    assign sq_trial = SQREM_W'({r_root, 2'b01});
    assign sq_ge    = (sq_rs >= sq_trial);
    assign root_new = {r_root[SQRT_W-2:0], sq_ge};

    assign wr_seg.sx = r_item.sx;
    assign wr_seg.sy = r_item.sy;
    assign wr_seg.ex = r_item.ex;
    assign wr_seg.ey = r_item.ey;
    assign wr_seg.nx = r_nnx;
    assign wr_seg.ny = r_nny;
    assign ram_we    = (r_state == S_WRITE);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_NSQ1: begin
                mul_a = MUL_W'($signed(r_item.nx));
                mul_b = MUL_W'($signed(r_item.nx));
            end
            S_NSQ2: begin
                mul_a = MUL_W'($signed(r_item.ny));
                mul_b = MUL_W'($signed(r_item.ny));
            end
            S_L1: begin
                mul_a = MUL_W'(r_dx);
                mul_b = MUL_W'(r_dx);
            end
            S_L2: begin
                mul_a = MUL_W'(r_dy);
                mul_b = MUL_W'(r_dy);
            end
            S_D1: begin
                mul_a = MUL_W'(r_wx);
                mul_b = MUL_W'(r_dx);
            end
            S_D2: begin
                mul_a = MUL_W'(r_wy);
                mul_b = MUL_W'(r_dy);
            end
            S_PX0: begin
                mul_a = $signed(MUL_W'(r_dot[QB-1:0]));
                mul_b = $signed(MUL_W'(abs_dx));
            end
            S_PX1: begin
                mul_a = $signed(MUL_W'(r_dot[SQ_W-1:QB]));
                mul_b = $signed(MUL_W'(abs_dx));
            end
            S_PY0: begin
                mul_a = $signed(MUL_W'(r_dot[QB-1:0]));
                mul_b = $signed(MUL_W'(abs_dy));
            end
            S_PY1: begin
                mul_a = $signed(MUL_W'(r_dot[SQ_W-1:QB]));
                mul_b = $signed(MUL_W'(abs_dy));
            end
            S_E1: begin
                mul_a = MUL_W'(r_ex);
                mul_b = MUL_W'(r_ex);
            end
            S_E2: begin
                mul_a = MUL_W'(r_ey);
                mul_b = MUL_W'(r_ey);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_item.op)
                        OP_APPEND: n_state = (r_count == CNT_W'(MAX_SEGMENTS)) ? S_RES : S_NSQ1;
                        OP_QUERY:  n_state = (r_count == '0) ? S_RES : S_RD;
                        default:   n_state = S_RES;
                    endcase
                end
            end
            S_NSQ1:  n_state = S_NSQ2;
            S_NSQ2:  n_state = S_SQRT;
            S_SQRT: begin
                if (last_step) begin
                    if (!r_sq_norm) begin
                        n_state = S_RES;
                    end else if (root_new == '0) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_NDX;
                    end
                end
            end
            S_NDX:   n_state = S_DIV;
            S_NDY:   n_state = S_DIV;
            S_DIV: begin
                if (last_step) begin
                    unique case (r_tgt)
                        TGT_NX:  n_state = S_NDY;
                        TGT_NY:  n_state = S_WRITE;
                        TGT_PX:  n_state = S_PY0;
                        default: n_state = S_E0;
                    endcase
                end
            end
            S_WRITE: n_state = S_RES;
            S_RD:    n_state = S_DIFF;
            S_DIFF:  n_state = S_L1;
            S_L1:    n_state = S_L2;
            S_L2:    n_state = S_D1;
            S_D1:    n_state = S_D2;
            S_D2:    n_state = S_CLS;
            S_CLS: begin
                if (r_len2 == '0 || r_dot[DOT_W-1] || r_dot == '0
                    || $unsigned(r_dot) >= DOT_W'(r_len2)) begin
                    n_state = S_E0;
                end else begin
                    n_state = S_PX0;
                end
            end
            S_PX0:   n_state = S_PX1;
            S_PX1:   n_state = S_DIV;
            S_PY0:   n_state = S_PY1;
            S_PY1:   n_state = S_DIV;
            S_E0:    n_state = S_E1;
            S_E1:    n_state = S_E2;
            S_E2:    n_state = S_CMP;
            S_CMP:   n_state = (r_idx + CNT_W'(1) == r_count) ? S_SQRT : S_RD;
            S_RES:   n_state = slot_free ? S_IDLE : S_RES;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        logic [QB+1:0]     off;
        logic [QB+1:0]     pos;
        logic [NORM_W-1:0] nq;
        logic [DIFF_W-1:0] nmag;
        logic              better;

        n_item      = r_item;
        n_count     = r_count;
        n_idx       = r_idx;
        n_step      = r_step;
        n_tgt       = r_tgt;
        n_sq_norm   = r_sq_norm;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_wx        = r_wx;
        n_wy        = r_wy;
        n_len2      = r_len2;
        n_d2        = r_d2;
        n_best      = r_best;
        n_div       = r_div;
        n_dot       = r_dot;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_nlo       = r_nlo;
        n_quo       = r_quo;
        n_px        = r_px;
        n_py        = r_py;
        n_ex        = r_ex;
        n_ey        = r_ey;
        n_bx        = r_bx;
        n_by        = r_by;
        n_bnx       = r_bnx;
        n_bny       = r_bny;
        n_nnx       = r_nnx;
        n_nny       = r_nny;
        n_sq_op     = r_sq_op;
        n_sq_rem    = r_sq_rem;
        n_root      = r_root;
        n_nlen      = r_nlen;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        o_pop       = 1'b0;
        off         = '0;
        pos         = '0;
        nq          = '0;
        nmag        = '0;
        better      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_pop  = 1'b1;
                    n_item = i_item;
                    n_res  = '0;
                    n_idx  = '0;
                    unique case (i_item.op)
                        OP_APPEND: begin
                            if (r_count == CNT_W'(MAX_SEGMENTS)) begin
                                n_res.status = STAT_FULL;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_QUERY: begin
                            if (r_count == '0) begin
                                n_res.status = STAT_EMPTY;
                            end
                        end
                        default: n_res.status = STAT_DONE;
                    endcase
                end
            end
            S_NSQ1: begin
                n_acc = PROD_W'($unsigned(mul_p));
            end
            S_NSQ2: begin
                n_sq_op   = DOT_W'(r_acc + PROD_W'($unsigned(mul_p)));
                n_sq_rem  = '0;
                n_root    = '0;
                n_step    = STEP_W'(SQRT_W);
                n_sq_norm = 1'b1;
            end
            S_SQRT: begin
                n_sq_rem = sq_ge ? sq_rs - sq_trial : sq_rs;
                n_root   = root_new;
                n_sq_op  = {r_sq_op[DOT_W-3:0], 2'b00};
                n_step   = r_step - STEP_W'(1);
                if (last_step) begin
                    if (r_sq_norm) begin
                        n_nlen = COORD_W'(root_new);
                        n_nnx  = '0;
                        n_nny  = '0;
                    end else begin
                        n_res.status   = STAT_HIT;
                        n_res.x        = r_bx;
                        n_res.y        = r_by;
                        n_res.nx       = r_bnx;
                        n_res.ny       = r_bny;
                        n_res.distance = DIST_W'(root_new);
                    end
                end
            end
            S_NDX, S_NDY: begin
                nmag   = (r_state == S_NDX)
                         ? (r_item.nx[COORD_W-1] ? DIFF_W'(-$signed(r_item.nx))
                                                  : DIFF_W'(r_item.nx))
                         : (r_item.ny[COORD_W-1] ? DIFF_W'(-$signed(r_item.ny))
                                                  : DIFF_W'(r_item.ny));
                n_rem  = DOT_W'(nmag >> 1);
                n_nlo  = {nmag[0], {(QB-1){1'b0}}};
                n_div  = SQ_W'(r_nlen);
                n_quo  = '0;
                n_step = STEP_W'(NDIV_BITS);
                n_tgt  = (r_state == S_NDX) ? TGT_NX : TGT_NY;
            end
            S_DIV: begin
                n_rem  = div_ge ? div_rs - DOT_W'(r_div) : div_rs;
                n_quo  = quo_new;
                n_nlo  = {r_nlo[QB-2:0], 1'b0};
                n_step = r_step - STEP_W'(1);
                if (last_step) begin
                    nq  = NORM_W'(quo_new[NDIV_BITS-1:0]);
                    off = (QB+2)'(quo_new);
                    unique case (r_tgt)
                        TGT_NX: n_nnx = r_item.nx[COORD_W-1] ? -nq : nq;
                        TGT_NY: n_nny = r_item.ny[COORD_W-1] ? -nq : nq;
                        TGT_PX: begin
                            pos  = (QB+2)'($signed(rd_seg.ex))
                                   + (r_dx[DIFF_W-1] ? -off : off);
                            n_px = pos[COORD_W-1:0];
                        end
                        default: begin
                            pos  = (QB+2)'($signed(rd_seg.ey))
                                   + (r_dy[DIFF_W-1] ? -off : off);
                            n_py = pos[COORD_W-1:0];
                        end
                    endcase
                end
            end
            S_WRITE: begin
                n_count = r_count + CNT_W'(1);
            end
            S_DIFF: begin
                n_dx = DIFF_W'($signed(rd_seg.sx)) - DIFF_W'($signed(rd_seg.ex));
                n_dy = DIFF_W'($signed(rd_seg.sy)) - DIFF_W'($signed(rd_seg.ey));
                n_wx = DIFF_W'($signed(r_item.qx)) - DIFF_W'($signed(rd_seg.ex));
                n_wy = DIFF_W'($signed(r_item.qy)) - DIFF_W'($signed(rd_seg.ey));
            end
            S_L1: n_len2 = SQ_W'($unsigned(mul_p));
            S_L2: n_len2 = r_len2 + SQ_W'($unsigned(mul_p));
            S_D1: n_dot  = DOT_W'(mul_p);
            S_D2: n_dot  = r_dot + DOT_W'(mul_p);
            S_CLS: begin
                if (r_len2 == '0 || r_dot[DOT_W-1] || r_dot == '0) begin
                    n_px = rd_seg.ex;
                    n_py = rd_seg.ey;
                end else if ($unsigned(r_dot) >= DOT_W'(r_len2)) begin
                    n_px = rd_seg.sx;
                    n_py = rd_seg.sy;
                end
            end
            S_PX0, S_PY0: begin
                n_acc = PROD_W'($unsigned(mul_p));
            end
            S_PX1, S_PY1: begin
                n_acc  = r_acc + (PROD_W'($unsigned(mul_p)) << QB);
                n_rem  = DOT_W'(n_acc[PROD_W-1:QB]);
                n_nlo  = n_acc[QB-1:0];
                n_div  = r_len2;
                n_quo  = '0;
                n_step = STEP_W'(QB);
                n_tgt  = (r_state == S_PX1) ? TGT_PX : TGT_PY;
            end
            S_E0: begin
                n_ex = DIFF_W'($signed(r_item.qx)) - DIFF_W'($signed(r_px));
                n_ey = DIFF_W'($signed(r_item.qy)) - DIFF_W'($signed(r_py));
            end
            S_E1: n_acc = PROD_W'($unsigned(mul_p));
            S_E2: n_d2  = SQ_W'(r_acc + PROD_W'($unsigned(mul_p)));
            S_CMP: begin
                better = (r_idx == '0) || (r_d2 < r_best);
                if (better) begin
                    n_best = r_d2;
                    n_bx   = r_px;
                    n_by   = r_py;
                    n_bnx  = rd_seg.nx;
                    n_bny  = rd_seg.ny;
                end
                n_idx     = r_idx + CNT_W'(1);
                n_sq_op   = DOT_W'(n_best);
                n_sq_rem  = '0;
                n_root    = '0;
                n_step    = STEP_W'(SQRT_W);
                n_sq_norm = 1'b0;
            end
            S_RES: begin
                if (slot_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_step   <= n_step;
        r_tgt    <= n_tgt;
        r_sq_norm <= n_sq_norm;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_wx     <= n_wx;
        r_wy     <= n_wy;
        r_len2   <= n_len2;
        r_d2     <= n_d2;
        r_best   <= n_best;
        r_div    <= n_div;
        r_dot    <= n_dot;
        r_acc    <= n_acc;
        r_rem    <= n_rem;
        r_nlo    <= n_nlo;
        r_quo    <= n_quo;
        r_px     <= n_px;
        r_py     <= n_py;
        r_ex     <= n_ex;
        r_ey     <= n_ey;
        r_bx     <= n_bx;
        r_by     <= n_by;
        r_bnx    <= n_bnx;
        r_bny    <= n_bny;
        r_nnx    <= n_nnx;
        r_nny    <= n_nny;
        r_sq_op  <= n_sq_op;
        r_sq_rem <= n_sq_rem;
        r_root   <= n_root;
        r_nlen   <= n_nlen;
        r_res    <= n_res;
        r_out    <= n_out;
        r_idx    <= n_idx;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the closest point on segment set block.
//
// Drives append, clear, query and unused-code words over the input stream
// and predicts each output word from a bit-exact model of the segment table.
// Each output word is checked field by field against the oldest prediction.
// Both stream sides stall in random bursts, except at the end of the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import clpt_pkg::*;;

    typedef logic signed [159:0] t_wide;

    localparam int IDLE_LIMIT = 40000;

    class seg_table_scoreboard;
        t_seg        table_q[MAX_SEGMENTS];
        int          seg_cnt;
        t_result     pending_q[$];
        int          errors;

        function new();
            seg_cnt = 0;
            errors  = 0;
        endfunction

        function automatic logic [63:0] isqrt(t_wide n);
            logic [63:0] r;
            logic [63:0] c;
            t_wide       cc;
            r = '0;
            for (int b = 40; b >= 0; b--) begin
                c  = r | (64'd1 << b);
                cc = t_wide'(c);
                if (cc * cc <= n) r = c;
            end
            return r;
        endfunction

        function automatic logic [NORM_W-1:0] unit_comp(t_wide c, logic [63:0] len);
            t_wide m;
            t_wide q;
            if (len == 0) return '0;
            m = (c < 0) ? -c : c;
            q = (m <<< 16) / t_wide'(len);
            return (c < 0) ? NORM_W'(-q) : NORM_W'(q);
        endfunction

        function void note(t_item it);
            t_result r;
            t_wide nx, ny, ax, ay, ex, ey, dx, dy, wx, wy, qx, qy;
            t_wide len2, dot, px, py, ox, oy, d2, best;
            logic [63:0] len;
            bit have;
            r = '0;
            r.status = STAT_DONE;
            case (it.op)
                OP_APPEND: begin
                    if (seg_cnt >= MAX_SEGMENTS) begin
                        r.status = STAT_FULL;
                    end else begin
                        nx  = t_wide'($signed(it.nx));
                        ny  = t_wide'($signed(it.ny));
                        len = isqrt(nx * nx + ny * ny);
                        table_q[seg_cnt] = '{it.sx, it.sy, it.ex, it.ey,
                                             unit_comp(nx, len), unit_comp(ny, len)};
                        seg_cnt++;
                    end
                end
                OP_CLEAR: seg_cnt = 0;
                OP_QUERY: begin
                    if (seg_cnt == 0) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        qx = t_wide'($signed(it.qx));
                        qy = t_wide'($signed(it.qy));
                        have = 0;
                        best = '0;
                        for (int i = 0; i < seg_cnt; i++) begin
                            ax = t_wide'($signed(table_q[i].sx));
                            ay = t_wide'($signed(table_q[i].sy));
                            ex = t_wide'($signed(table_q[i].ex));
                            ey = t_wide'($signed(table_q[i].ey));
                            dx = ax - ex;
                            dy = ay - ey;
                            wx = qx - ex;
                            wy = qy - ey;
                            len2 = dx * dx + dy * dy;
                            dot  = wx * dx + wy * dy;
                            if (len2 == 0 || dot <= 0) begin
                                px = ex;
                                py = ey;
                            end else if (dot >= len2) begin
                                px = ax;
                                py = ay;
                            end else begin
                                ox = (dot * ((dx < 0) ? -dx : dx)) / len2;
                                oy = (dot * ((dy < 0) ? -dy : dy)) / len2;
                                px = ex + ((dx < 0) ? -ox : ox);
                                py = ey + ((dy < 0) ? -oy : oy);
                            end
                            d2 = (qx - px) * (qx - px) + (qy - py) * (qy - py);
                            if (!have || d2 < best) begin
                                have = 1;
                                best = d2;
                                r.x  = px[COORD_W-1:0];
                                r.y  = py[COORD_W-1:0];
                                r.nx = table_q[i].nx;
                                r.ny = table_q[i].ny;
                            end
                        end
                        r.status   = STAT_HIT;
                        r.distance = DIST_W'(isqrt(best));
                    end
                end
                default: ;
            endcase
            pending_q.push_back(r);
        endfunction

        function void check(logic [1:0] status, logic [135:0] data);
            t_result e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected word status=%0d data=%h", $time, status, data);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (status != e.status) begin
                $display("%0t: status exp %0d act %0d", $time, e.status, status);
                errors++;
            end
            if (data[31:0] != e.x) begin
                $display("%0t: nearest_x exp %h act %h", $time, e.x, data[31:0]);
                errors++;
            end
            if (data[63:32] != e.y) begin
                $display("%0t: nearest_y exp %h act %h", $time, e.y, data[63:32]);
                errors++;
            end
            if (data[81:64] != e.nx) begin
                $display("%0t: normal_x exp %h act %h", $time, e.nx, data[81:64]);
                errors++;
            end
            if (data[99:82] != e.ny) begin
                $display("%0t: normal_y exp %h act %h", $time, e.ny, data[99:82]);
                errors++;
            end
            if (data[132:100] != e.distance) begin
                $display("%0t: distance exp %h act %h", $time, e.distance, data[132:100]);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata;    // start_x, start_y, end_x, end_y, normal_x, normal_y, query_x, query_y
    logic [1:0]   s_axis_tuser;    // operation
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;    // nearest_x, nearest_y, normal_x, normal_y, distance, pad
    logic [1:0]   m_axis_tuser;    // status

    seg_table_scoreboard sb = new();
    bit quiet;
    int stall_left;
    int idle_cycles;

    closest_point_on_segment_set_top i_dut (.*);

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) sb.check(m_axis_tuser, m_axis_tdata);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left    <= stall_left - 1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left    <= $urandom_range(1, 12) - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
            2: case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0;
                default: return 32'hffff_ffff;
            endcase
            default: return 32'($signed($urandom_range(0, 2 ** 27)) - 2 ** 26);
        endcase
    endfunction

    function automatic t_item rand_item(t_op op);
        t_item it;
        it.op = op;
        it.sx = rand_coord();
        it.sy = rand_coord();
        it.ex = rand_coord();
        it.ey = rand_coord();
        it.nx = rand_coord();
        it.ny = rand_coord();
        it.qx = rand_coord();
        it.qy = rand_coord();
        if ($urandom_range(0, 9) == 0) begin
            it.ex = it.sx;
            it.ey = it.sy;
        end
        if ($urandom_range(0, 9) == 0) it.nx = '0;
        if ($urandom_range(0, 9) == 0) it.ny = '0;
        return it;
    endfunction

    function automatic t_item mk(t_op op, int sx, int sy, int ex, int ey,
                                 int nx, int ny, int qx, int qy);
        return '{op, sx, sy, ex, ey, nx, ny, qx, qy};
    endfunction

    task automatic send(t_item it);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.qy, it.qx, it.ny, it.nx, it.ey, it.ex, it.sy, it.sx};
        s_axis_tuser  <= it.op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note(it);
    endtask

    initial begin
        int r;
        t_op op;
        quiet         = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_NOP;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, unused code, basic geometry, ties, extremes
        send(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 65536, 65536));
        send(mk(OP_NOP, -1, -1, -1, -1, -1, -1, -1, -1));
        send(mk(OP_APPEND, 0, 0, 10 << 16, 0, 0, 3 << 16, 0, 0));
        send(mk(OP_APPEND, 0, 0, 10 << 16, 0, 4 << 16, 0, 0, 0));
        send(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 5 << 16, 7 << 16));
        send(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, -(3 << 16), 2 << 16));
        send(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 13 << 16, -(1 << 16)));
        send(mk(OP_APPEND, 5 << 16, 5 << 16, 5 << 16, 5 << 16, 0, 0, 0, 0));
        send(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 5 << 16, 6 << 16));
        send(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(OP_APPEND, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h8000_0000, 32'h8000_0000, 0, 0));
        send(mk(OP_APPEND, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                32'h7fff_ffff, 32'h8000_0000, 0, 0));
        send(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000));
        send(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000));
        send(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 12345, -98765));
        send(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));

        // fill the table past its depth, then query a full table
        for (int i = 0; i < MAX_SEGMENTS + 2; i++) send(rand_item(OP_APPEND));
        repeat (3) send(rand_item(OP_QUERY));
        send(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));

        for (int n = 0; n < 470; n++) begin
            if (n >= 420) quiet = 1;
            r = $urandom_range(0, 99);
            if (r < 50) op = OP_APPEND;
            else if (r < 90) op = OP_QUERY;
            else if (r < 96) op = OP_CLEAR;
            else op = OP_NOP;
            send(rand_item(op));
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
